// ----- hw/rtl/hcp_pkg.sv -----
// Package for the homography crop block: shared widths, codes and payload types.
// Used by hcp_front, hcp_back and the top level; it depends on nothing else.
package hcp_pkg;

  // Field and arithmetic widths.
  localparam int COEF_W     = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DIM_W      = 13;
  localparam int SAT_BITS   = 20;
  localparam int PROD_W     = COEF_W + DIM_W + 1;
  localparam int SUM_W      = PROD_W + 2;
  localparam int MAG_W      = SUM_W - 1;
  localparam int PROJ_Q_W   = SAT_BITS + FRAC_BITS;
  localparam int COORD_W    = PROJ_Q_W + 2;
  localparam int SIDE_W     = DIM_W + FRAC_BITS;
  localparam int OV_W       = COORD_W + 2;
  localparam int PCT_W      = 23;
  localparam int PCT_NUM_W  = DIM_W + PCT_W;

  // Constants.
  localparam logic [PCT_W-1:0] PCT_FULL  = 23'd6553600;
  localparam int               PCT_SCALE = 100;
  localparam logic [DIM_W-1:0] FW_RESET  = 13'd1920;
  localparam logic [DIM_W-1:0] FH_RESET  = 13'd1080;

  // Configuration register indexes.
  localparam int                CFG_IDX_W        = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  // Result buffer geometry.
  localparam int OUT_DEPTH = 32;
  localparam int OUT_PTR_W = 5;
  localparam int CREDIT_W  = OUT_PTR_W + 1;

  // Frame corners in projection order.
  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BR = 2'd2,
    CORNER_BL = 2'd3
  } corner_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] h00;
    logic signed [COEF_W-1:0] h01;
    logic signed [COEF_W-1:0] h02;
    logic signed [COEF_W-1:0] h10;
    logic signed [COEF_W-1:0] h11;
    logic signed [COEF_W-1:0] h12;
    logic signed [COEF_W-1:0] h20;
    logic signed [COEF_W-1:0] h21;
    logic signed [COEF_W-1:0] h22;
  } in_item_t;

  typedef struct packed {
    logic [PCT_W-1:0] crop_percent;
    logic             no_overlap;
  } out_item_t;

  // One queued job: coefficients plus the frame size captured at acceptance.
  typedef struct packed {
    in_item_t         coef;
    logic [DIM_W-1:0] fw;
    logic [DIM_W-1:0] fh;
    logic             zero_frame;
  } job_t;

  // Sideband carried through a projection divider.
  typedef struct packed {
    corner_t          corner;
    logic             zero;
    logic             neg;
    logic             sat;
    logic             zero_frame;
    logic [DIM_W-1:0] fw;
    logic [DIM_W-1:0] fh;
  } proj_tag_t;

  // Sideband carried through a percentage divider.
  typedef struct packed {
    logic no_overlap;
  } pct_tag_t;

endpackage

// ----- hw/rtl/hcp_udiv.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a sideband tag.
// Stand-alone; the caller guarantees the quotient fits in Q_W bits.
module hcp_udiv #(
  parameter int DEN_W = 13,
  parameter int Q_W   = 23,
  parameter int TAG_W = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [DEN_W+Q_W-1:0]   in_num,
  input  logic [DEN_W-1:0]       in_den,
  input  logic [TAG_W-1:0]       in_tag,
  output logic                   out_valid,
  output logic [Q_W-1:0]         out_quo,
  output logic [TAG_W-1:0]       out_tag
);

  logic             vld  [0:Q_W];
  logic [DEN_W-1:0] rem  [0:Q_W];
  logic [Q_W-1:0]   rq   [0:Q_W];
  logic [DEN_W-1:0] den  [0:Q_W];
  logic [TAG_W-1:0] tag  [0:Q_W];
  logic [DEN_W:0]   trial[0:Q_W-1];
  logic             ge   [0:Q_W-1];

  // Trial subtraction for every stage.
  always_comb begin
    for (int k = 0; k < Q_W; k++) begin
      trial[k] = {rem[k], rq[k][Q_W-1]};
      ge[k]    = trial[k] >= {1'b0, den[k]};
    end
  end

  // Stage registers; the low numerator bits and the quotient share one shifting word.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= Q_W; k++) vld[k] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int k = 0; k < Q_W; k++) vld[k+1] <= vld[k];
    end
    rem[0] <= in_num[DEN_W+Q_W-1:Q_W];
    rq[0]  <= in_num[Q_W-1:0];
    den[0] <= in_den;
    tag[0] <= in_tag;
    for (int k = 0; k < Q_W; k++) begin
      rem[k+1] <= ge[k] ? DEN_W'(trial[k] - {1'b0, den[k]}) : trial[k][DEN_W-1:0];
      rq[k+1]  <= {rq[k][Q_W-2:0], ge[k]};
      den[k+1] <= den[k];
      tag[k+1] <= tag[k];
    end
  end

  assign out_valid = vld[Q_W];
  assign out_quo   = rq[Q_W];
  assign out_tag   = tag[Q_W];

endmodule

// ----- hw/rtl/hcp_front.sv -----
// Front end: configuration registers, input acceptance and a two-entry job queue.
// Depends on hcp_pkg.
module hcp_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [hcp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hcp_pkg::DIM_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  hcp_pkg::in_item_t               in_data,
  output logic                            q_valid,
  input  logic                            q_pop,
  output hcp_pkg::job_t                   q_job
);

  logic [hcp_pkg::DIM_W-1:0] frame_width;
  logic [hcp_pkg::DIM_W-1:0] frame_height;
  hcp_pkg::job_t             entry [0:1];
  logic                      wr_ptr;
  logic                      rd_ptr;
  logic [1:0]                count;
  logic                      push;

  // Frame size registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= hcp_pkg::FW_RESET;
      frame_height <= hcp_pkg::FH_RESET;
    end else if (cfg_we) begin
      if (cfg_index == hcp_pkg::CFG_FRAME_WIDTH) frame_width <= cfg_data;
      if (cfg_index == hcp_pkg::CFG_FRAME_HEIGHT) frame_height <= cfg_data;
    end
  end

  // A transaction is taken while the queue has room; degenerate frames are marked.
  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
    if (push) begin
      entry[wr_ptr].coef       <= in_data;
      entry[wr_ptr].fw         <= frame_width;
      entry[wr_ptr].fh         <= frame_height;
      entry[wr_ptr].zero_frame <= (frame_width == '0) || (frame_height == '0);
    end
  end

  assign q_valid = (count != 2'd0);
  assign q_job   = entry[rd_ptr];

endmodule

// ----- hw/rtl/hcp_back.sv -----
// Back end: corner projection, perspective divide, bounding box, crop percentage
// and the result buffer. Depends on hcp_pkg and hcp_udiv.
module hcp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_pop,
  input  hcp_pkg::job_t       q_job,
  output logic                out_valid,
  input  logic                out_stall,
  output hcp_pkg::out_item_t  out_data
);

  localparam int PW = hcp_pkg::PROD_W;
  localparam int SW = hcp_pkg::SUM_W;
  localparam int MW = hcp_pkg::MAG_W;
  localparam int CW = hcp_pkg::COORD_W;
  localparam int OW = hcp_pkg::OV_W;
  localparam int DW = hcp_pkg::DIM_W;
  localparam int FB = hcp_pkg::FRAC_BITS;
  localparam int QW = hcp_pkg::PROJ_Q_W;

  // Corner sequencer and result credits.
  logic [1:0]                      corner_idx;
  logic [hcp_pkg::CREDIT_W-1:0]    credit;
  logic                            start_ok;
  logic                            issue;
  logic                            start;
  logic                            out_take;

  assign start_ok = (corner_idx != hcp_pkg::CORNER_TL) ||
                    (credit < hcp_pkg::CREDIT_W'(hcp_pkg::OUT_DEPTH));
  assign issue    = q_valid && start_ok;
  assign start    = issue && (corner_idx == hcp_pkg::CORNER_TL);
  assign q_pop    = issue && (corner_idx == hcp_pkg::CORNER_BL);
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_idx <= 2'd0;
      credit     <= '0;
    end else begin
      if (issue) corner_idx <= corner_idx + 2'd1;
      credit <= credit + hcp_pkg::CREDIT_W'(start) - hcp_pkg::CREDIT_W'(out_take);
    end
  end

  // Corner coordinates and the six products.
  logic [DW-1:0]        cx_pix;
  logic [DW-1:0]        cy_pix;
  logic signed [DW:0]   xs;
  logic signed [DW:0]   ys;

  assign cx_pix = ((corner_idx == hcp_pkg::CORNER_TR) || (corner_idx == hcp_pkg::CORNER_BR))
                  ? q_job.fw : '0;
  assign cy_pix = ((corner_idx == hcp_pkg::CORNER_BR) || (corner_idx == hcp_pkg::CORNER_BL))
                  ? q_job.fh : '0;
  assign xs = $signed({1'b0, cx_pix});
  assign ys = $signed({1'b0, cy_pix});

  logic                              s1_valid;
  hcp_pkg::corner_t                  s1_corner;
  logic signed [PW-1:0]              s1_xx, s1_xy, s1_yx, s1_yy, s1_wx, s1_wy;
  logic signed [hcp_pkg::COEF_W-1:0] s1_xc, s1_yc, s1_wc;
  logic [DW-1:0]                     s1_fw, s1_fh;
  logic                              s1_zf;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= issue;
    s1_corner <= hcp_pkg::corner_t'(corner_idx);
    s1_xx <= PW'(q_job.coef.h00) * PW'(xs);
    s1_xy <= PW'(q_job.coef.h01) * PW'(ys);
    s1_yx <= PW'(q_job.coef.h10) * PW'(xs);
    s1_yy <= PW'(q_job.coef.h11) * PW'(ys);
    s1_wx <= PW'(q_job.coef.h20) * PW'(xs);
    s1_wy <= PW'(q_job.coef.h21) * PW'(ys);
    s1_xc <= q_job.coef.h02;
    s1_yc <= q_job.coef.h12;
    s1_wc <= q_job.coef.h22;
    s1_fw <= q_job.fw;
    s1_fh <= q_job.fh;
    s1_zf <= q_job.zero_frame;
  end

  // Homogeneous sums.
  logic                 s2_valid;
  hcp_pkg::corner_t     s2_corner;
  logic signed [SW-1:0] s2_nx, s2_ny, s2_nw;
  logic [DW-1:0]        s2_fw, s2_fh;
  logic                 s2_zf;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else     s2_valid <= s1_valid;
    s2_corner <= s1_corner;
    s2_nx <= SW'(s1_xx) + SW'(s1_xy) + SW'(s1_xc);
    s2_ny <= SW'(s1_yx) + SW'(s1_yy) + SW'(s1_yc);
    s2_nw <= SW'(s1_wx) + SW'(s1_wy) + SW'(s1_wc);
    s2_fw <= s1_fw;
    s2_fh <= s1_fh;
    s2_zf <= s1_zf;
  end

  // Magnitudes, signs and saturation check ahead of the dividers.
  logic [MW-1:0]       ax, ay, aw;
  hcp_pkg::proj_tag_t  tag_x_in, tag_y_in, tag_x_out, tag_y_out;
  logic [MW+QW-1:0]    num_x, num_y;

  assign ax = s2_nx[SW-1] ? MW'(-s2_nx) : MW'(s2_nx);
  assign ay = s2_ny[SW-1] ? MW'(-s2_ny) : MW'(s2_ny);
  assign aw = s2_nw[SW-1] ? MW'(-s2_nw) : MW'(s2_nw);

  assign num_x = {(QW-FB)'(0), ax, FB'(0)};
  assign num_y = {(QW-FB)'(0), ay, FB'(0)};

  always_comb begin
    tag_x_in.corner     = s2_corner;
    tag_x_in.zero       = (s2_nw == '0);
    tag_x_in.neg        = s2_nx[SW-1] ^ s2_nw[SW-1];
    tag_x_in.sat        = (MW+hcp_pkg::SAT_BITS)'(ax) >= {aw, hcp_pkg::SAT_BITS'(0)};
    tag_x_in.zero_frame = s2_zf;
    tag_x_in.fw         = s2_fw;
    tag_x_in.fh         = s2_fh;
    tag_y_in            = tag_x_in;
    tag_y_in.neg        = s2_ny[SW-1] ^ s2_nw[SW-1];
    tag_y_in.sat        = (MW+hcp_pkg::SAT_BITS)'(ay) >= {aw, hcp_pkg::SAT_BITS'(0)};
  end

  logic          dx_valid, dy_valid;
  logic [QW-1:0] qx, qy;
  logic [$bits(hcp_pkg::proj_tag_t)-1:0] tx_bits, ty_bits;

  hcp_udiv #(.DEN_W(MW), .Q_W(QW), .TAG_W($bits(hcp_pkg::proj_tag_t))) u_div_x (
    .clk(clk), .rst(rst), .in_valid(s2_valid), .in_num(num_x), .in_den(aw),
    .in_tag(tag_x_in), .out_valid(dx_valid), .out_quo(qx), .out_tag(tx_bits)
  );

  hcp_udiv #(.DEN_W(MW), .Q_W(QW), .TAG_W($bits(hcp_pkg::proj_tag_t))) u_div_y (
    .clk(clk), .rst(rst), .in_valid(s2_valid), .in_num(num_y), .in_den(aw),
    .in_tag(tag_y_in), .out_valid(dy_valid), .out_quo(qy), .out_tag(ty_bits)
  );

  assign tag_x_out = hcp_pkg::proj_tag_t'(tx_bits);
  assign tag_y_out = hcp_pkg::proj_tag_t'(ty_bits);

  // Apply saturation, sign and the vanishing-w case.
  logic [QW:0]          mag_x, mag_y;
  logic                 s4_valid;
  hcp_pkg::corner_t     s4_corner;
  logic signed [CW-1:0] s4_px, s4_py;
  logic [DW-1:0]        s4_fw, s4_fh;
  logic                 s4_zf;

  assign mag_x = tag_x_out.sat ? {1'b1, QW'(0)} : {1'b0, qx};
  assign mag_y = tag_y_out.sat ? {1'b1, QW'(0)} : {1'b0, qy};

  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else     s4_valid <= dx_valid && dy_valid;
    s4_corner <= tag_x_out.corner;
    s4_px <= tag_x_out.zero ? '0 : (tag_x_out.neg ? -CW'(mag_x) : CW'(mag_x));
    s4_py <= tag_x_out.zero ? '0 : (tag_y_out.neg ? -CW'(mag_y) : CW'(mag_y));
    s4_fw <= tag_x_out.fw;
    s4_fh <= tag_x_out.fh;
    s4_zf <= tag_x_out.zero_frame;
  end

  // Bounding box over the four corners.
  logic signed [CW-1:0] minx, maxx, miny, maxy;
  logic                 s5_valid;
  logic [DW-1:0]        s5_fw, s5_fh;
  logic                 s5_zf;
  logic                 first;

  assign first = (s4_corner == hcp_pkg::CORNER_TL);

  always_ff @(posedge clk) begin
    if (rst) s5_valid <= 1'b0;
    else     s5_valid <= s4_valid && (s4_corner == hcp_pkg::CORNER_BL);
    if (s4_valid) begin
      if (first || s4_px < minx) minx <= s4_px;
      if (first || s4_px > maxx) maxx <= s4_px;
      if (first || s4_py < miny) miny <= s4_py;
      if (first || s4_py > maxy) maxy <= s4_py;
    end
    s5_fw <= s4_fw;
    s5_fh <= s4_fh;
    s5_zf <= s4_zf;
  end

  // Overlap with the frame and the scaled uncovered extent.
  logic signed [OW-1:0]            sw_q, sh_q, hi_x, lo_x, hi_y, lo_y, ov_w, ov_h, one_q;
  logic signed [OW-1:0]            bminx, bmaxx, bminy, bmaxy;
  logic                            ov_flag;
  logic [hcp_pkg::SIDE_W-1:0]      dx, dy;

  always_comb begin
    sw_q  = $signed(OW'({s5_fw, FB'(0)}));
    sh_q  = $signed(OW'({s5_fh, FB'(0)}));
    one_q = $signed(OW'({1'b1, FB'(0)}));
    bminx = OW'(minx);
    bmaxx = OW'(maxx);
    bminy = OW'(miny);
    bmaxy = OW'(maxy);
    hi_x  = (bmaxx < sw_q) ? bmaxx : sw_q;
    lo_x  = (bminx > 0) ? bminx : '0;
    hi_y  = (bmaxy < sh_q) ? bmaxy : sh_q;
    lo_y  = (bminy > 0) ? bminy : '0;
    ov_w  = hi_x - lo_x;
    ov_h  = hi_y - lo_y;
    ov_flag = (ov_w <= one_q) || (ov_h <= one_q) || s5_zf;
    dx = ov_flag ? '0 : hcp_pkg::SIDE_W'(sw_q - ov_w);
    dy = ov_flag ? '0 : hcp_pkg::SIDE_W'(sh_q - ov_h);
  end

  logic                             s6_valid;
  logic [hcp_pkg::PCT_NUM_W-1:0]    s6_num_x, s6_num_y;
  logic [DW-1:0]                    s6_fw, s6_fh;
  hcp_pkg::pct_tag_t                s6_tag;

  always_ff @(posedge clk) begin
    if (rst) s6_valid <= 1'b0;
    else     s6_valid <= s5_valid;
    s6_num_x <= hcp_pkg::PCT_NUM_W'(dx) * hcp_pkg::PCT_NUM_W'(hcp_pkg::PCT_SCALE);
    s6_num_y <= hcp_pkg::PCT_NUM_W'(dy) * hcp_pkg::PCT_NUM_W'(hcp_pkg::PCT_SCALE);
    s6_fw <= s5_fw;
    s6_fh <= s5_fh;
    s6_tag.no_overlap <= ov_flag;
  end

  // Per-axis percentage: floor(100 * uncovered / side).
  logic                         px_valid, py_valid;
  logic [hcp_pkg::PCT_W-1:0]    pct_x, pct_y;
  logic [$bits(hcp_pkg::pct_tag_t)-1:0] ptag_bits, ptag_unused;
  hcp_pkg::pct_tag_t            ptag;

  hcp_udiv #(.DEN_W(DW), .Q_W(hcp_pkg::PCT_W), .TAG_W($bits(hcp_pkg::pct_tag_t))) u_pct_x (
    .clk(clk), .rst(rst), .in_valid(s6_valid), .in_num(s6_num_x), .in_den(s6_fw),
    .in_tag(s6_tag), .out_valid(px_valid), .out_quo(pct_x), .out_tag(ptag_bits)
  );

  hcp_udiv #(.DEN_W(DW), .Q_W(hcp_pkg::PCT_W), .TAG_W($bits(hcp_pkg::pct_tag_t))) u_pct_y (
    .clk(clk), .rst(rst), .in_valid(s6_valid), .in_num(s6_num_y), .in_den(s6_fh),
    .in_tag(s6_tag), .out_valid(py_valid), .out_quo(pct_y), .out_tag(ptag_unused)
  );

  assign ptag = hcp_pkg::pct_tag_t'(ptag_bits | ptag_unused);

  // Result buffer; credits keep it from overflowing.
  hcp_pkg::out_item_t          res_mem [0:hcp_pkg::OUT_DEPTH-1];
  hcp_pkg::out_item_t          res_item;
  logic [hcp_pkg::OUT_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [hcp_pkg::CREDIT_W-1:0]  out_count;
  logic                          push;

  assign push = px_valid && py_valid;

  always_comb begin
    res_item.no_overlap   = ptag.no_overlap;
    res_item.crop_percent = ptag.no_overlap ? hcp_pkg::PCT_FULL
                                            : ((pct_x > pct_y) ? pct_x : pct_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      out_count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (out_take) rd_ptr <= rd_ptr + 1'b1;
      out_count <= out_count + hcp_pkg::CREDIT_W'(push) - hcp_pkg::CREDIT_W'(out_take);
    end
    if (push) res_mem[wr_ptr] <= res_item;
  end

  assign out_valid = (out_count != '0);
  assign out_data  = res_mem[rd_ptr];

`ifndef ASSERT_OFF
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit <= hcp_pkg::CREDIT_W'(hcp_pkg::OUT_DEPTH))
    else $error("credit count above buffer depth");

  a_buffer_within_credit: assert property (@(posedge clk) disable iff (rst)
    out_count <= credit)
    else $error("buffered results exceed issued transactions");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (out_count < hcp_pkg::CREDIT_W'(hcp_pkg::OUT_DEPTH)) || out_take)
    else $error("result written into a full buffer");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.crop_percent <= hcp_pkg::PCT_FULL)
    else $error("crop percentage above full scale");
`endif

endmodule

// ----- hw/rtl/homography_crop_percent.sv -----
// Top level of the homography crop block: front end joined to the back end.
// Depends on hcp_pkg, hcp_front and hcp_back.
//
// Usage: the input channel (in_valid, in_stall, in_data) carries one 3x3
// homography per transaction; the output channel (out_valid, out_stall,
// out_data) returns one crop percentage and a no-overlap flag for each.
// Frame width and height are set through cfg_we, cfg_index and cfg_data
// while the block is idle; the values in effect when a transaction is
// accepted are the ones it uses.
// The four frame corners of each homography pass one after another
// through a single projection and divide path; a new homography is
// not started while the result buffer is committed full.
// Reset restores the frame size to 1920 x 1080 and empties the queue, the
// pipeline and the result buffer. When the receiver stalls, results collect
// in a 32-entry buffer; once it is committed full, new work waits in the
// input queue and in_stall rises.
module homography_crop_percent (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [hcp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hcp_pkg::DIM_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  hcp_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output hcp_pkg::out_item_t              out_data
);

  logic          q_valid;
  logic          q_pop;
  hcp_pkg::job_t q_job;

  hcp_front u_front (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .q_valid(q_valid), .q_pop(q_pop), .q_job(q_job)
  );

  hcp_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_pop(q_pop), .q_job(q_job),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule
